>>> hw/rtl/hcr_pkg.sv
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants of the height to colour ramp: register indexes,
// the item class code that travels down the divider row, and ramp constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hcr_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int SHADE_WIDTH    = 24;
   localparam int CHANNEL_BITS   = 8;
   localparam int INT_BITS       = 8;

   localparam int CH_FULL      = 255;
   localparam int CH_GREY      = 127;
   localparam int RAMP_G_SLOPE = 765;
   localparam int RAMP_R_SLOPE = 1530;
   localparam int RAMP_B_STEP  = 6;
   localparam int RAMP_G_STEP  = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_RANGE_MIN    = 3'd0,
      REG_RANGE_MID    = 3'd1,
      REG_RANGE_MAX    = 3'd2,
      REG_REVERSE_MAP  = 3'd3,
      REG_BLENDED_MODE = 3'd4,
      REG_SHADE_COLOUR = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_SHADE_GREY  = 3'd0,
      MODE_SHADE_WHITE = 3'd1,
      MODE_SHADE_DIV   = 3'd2,
      MODE_RAMP_GREEN  = 3'd3,
      MODE_RAMP_LOWER  = 3'd4,
      MODE_RAMP_UPPER  = 3'd5
   } mode_type;

   typedef struct packed {
      logic     valid;
      mode_type mode;
      logic     sat;
   } ctl_type;

endpackage

>>> hw/rtl/hcr_front.sv
// ----------------------------------------------------------------------------
// hcr_front
// Front stage: mirrors the height, classifies it and sets up the numerator
// and divisor for the divider row, including the quotient saturation check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcr_front #(
   parameter int HEIGHT_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic                           in_valid,
   input  logic signed [HEIGHT_WIDTH-1:0] height,
   input  logic signed [HEIGHT_WIDTH-1:0] range_min,
   input  logic signed [HEIGHT_WIDTH-1:0] range_mid,
   input  logic signed [HEIGHT_WIDTH-1:0] range_max,
   input  logic                           reverse_map,
   input  logic                           blended_mode,
   output hcr_pkg::ctl_type               ctl_o,
   output logic [HEIGHT_WIDTH:0]          rem_o,
   output logic [hcr_pkg::INT_BITS-1:0]   nbits_o,
   output logic [HEIGHT_WIDTH:0]          den_o
);

   import hcr_pkg::*;

   localparam int DW = HEIGHT_WIDTH + 1;
   localparam int NW = HEIGHT_WIDTH + 2;
   localparam int SW = HEIGHT_WIDTH + 3;

   ctl_type              ctl_ff;
   logic [DW-1:0]        rem_ff;
   logic [INT_BITS-1:0]  nbits_ff;
   logic [DW-1:0]        den_ff;

   mode_type             mode_in;
   logic                 sat_in;
   logic [NW-1:0]        num_in;
   logic [DW-1:0]        den_in;

   always_comb begin
      logic signed [SW-1:0] z, zr, mn, md, mx, rng, num_s, top, bot, nm;
      z     = SW'(height);
      mn    = SW'(range_min);
      md    = SW'(range_mid);
      mx    = SW'(range_max);
      zr    = reverse_map ? (mn + mx - z) : z;
      rng   = mx - mn;
      top   = mx - md;
      bot   = md - mn;
      nm    = zr - mn;
      num_s = '0;
      mode_in = MODE_RAMP_GREEN;
      num_in  = '0;
      den_in  = DW'(1);
      if (!blended_mode) begin
         num_s = mx - zr;
         if (rng[SW-1] || (rng == '0)) begin
            mode_in = MODE_SHADE_GREY;
         end else if (num_s[SW-1]) begin
            mode_in = MODE_SHADE_WHITE;
         end else begin
            mode_in = MODE_SHADE_DIV;
            num_in  = NW'(num_s);
            den_in  = DW'(rng);
         end
      end else if (rng[SW-1] || (rng == '0)) begin
         mode_in = MODE_RAMP_GREEN;
      end else if (zr > md) begin
         mode_in = MODE_RAMP_UPPER;
         num_s   = zr - md;
         if (top == '0) begin
            num_in = NW'(1) << INT_BITS;
         end else if (!top[SW-1]) begin
            num_in = NW'(num_s);
            den_in = DW'(top) << 1;
         end
      end else begin
         mode_in = MODE_RAMP_LOWER;
         if ((bot != '0) && !bot[SW-1] && !nm[SW-1]) begin
            num_in = NW'(nm);
            den_in = DW'(bot) << 1;
         end else if (bot[SW-1] && (nm[SW-1] || (nm == '0))) begin
            num_in = NW'(-nm);
            den_in = DW'(-bot) << 1;
         end
      end
      sat_in = (num_in >> INT_BITS) >= NW'(den_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (load) begin
         ctl_ff.valid <= in_valid;
      end
      if (load) begin
         ctl_ff.mode <= mode_in;
         ctl_ff.sat  <= sat_in;
         rem_ff      <= DW'(num_in >> INT_BITS);
         nbits_ff    <= num_in[INT_BITS-1:0];
         den_ff      <= den_in;
      end
   end

   assign ctl_o   = ctl_ff;
   assign rem_o   = rem_ff;
   assign nbits_o = nbits_ff;
   assign den_o   = den_ff;

endmodule

>>> hw/rtl/hcr_cell.sv
// ----------------------------------------------------------------------------
// hcr_cell
// One restoring divider cell: shifts in the next numerator bit, subtracts
// the divisor when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcr_cell #(
   parameter int DW = 33,
   parameter int QW = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         load,
   input  hcr_pkg::ctl_type             ctl_i,
   input  logic [DW-1:0]                rem_i,
   input  logic [hcr_pkg::INT_BITS-1:0] nbits_i,
   input  logic [DW-1:0]                den_i,
   input  logic [QW-1:0]                q_i,
   output hcr_pkg::ctl_type             ctl_o,
   output logic [DW-1:0]                rem_o,
   output logic [hcr_pkg::INT_BITS-1:0] nbits_o,
   output logic [DW-1:0]                den_o,
   output logic [QW-1:0]                q_o
);

   import hcr_pkg::*;

   ctl_type             ctl_ff;
   logic [DW-1:0]       rem_ff;
   logic [INT_BITS-1:0] nbits_ff;
   logic [DW-1:0]       den_ff;
   logic [QW-1:0]       q_ff;

   logic [DW:0]         trial;
   logic                fits;
   logic [DW-1:0]       rem_in;

   always_comb begin
      trial  = {rem_i, nbits_i[INT_BITS-1]};
      fits   = trial >= {1'b0, den_i};
      rem_in = fits ? DW'(trial - {1'b0, den_i}) : DW'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (load) begin
         ctl_ff.valid <= ctl_i.valid;
      end
      if (load) begin
         ctl_ff.mode <= ctl_i.mode;
         ctl_ff.sat  <= ctl_i.sat;
         rem_ff      <= rem_in;
         nbits_ff    <= {nbits_i[INT_BITS-2:0], 1'b0};
         den_ff      <= den_i;
         q_ff        <= {q_i[QW-2:0], fits};
      end
   end

   assign ctl_o   = ctl_ff;
   assign rem_o   = rem_ff;
   assign nbits_o = nbits_ff;
   assign den_o   = den_ff;
   assign q_o     = q_ff;

endmodule

>>> hw/rtl/hcr_colour.sv
// ----------------------------------------------------------------------------
// hcr_colour
// Back end: turns the quotient into a ramp position or shade fraction,
// forms the three channel values, then truncates and clamps them into the
// output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcr_colour #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load_a,
   input  logic                             load_b,
   input  hcr_pkg::ctl_type                 ctl_i,
   input  logic [FRACTION_BITS+hcr_pkg::INT_BITS-1:0] q_i,
   input  logic [hcr_pkg::SHADE_WIDTH-1:0]  shade_colour,
   output logic                             a_valid,
   output logic                             rsp_valid,
   output logic [hcr_pkg::CHANNEL_BITS-1:0] red,
   output logic [hcr_pkg::CHANNEL_BITS-1:0] green,
   output logic [hcr_pkg::CHANNEL_BITS-1:0] blue
);

   import hcr_pkg::*;

   localparam int F   = FRACTION_BITS;
   localparam int QW  = F + INT_BITS;
   localparam int XW  = F + 1;
   localparam int SCW = F + INT_BITS + 1;
   localparam int PW  = SCW + CHANNEL_BITS;
   localparam int VW  = F + 18;

   localparam int LOW_Q  = (33 * (1 << F) + 50) / 100;
   localparam int HIGH_Q = (66 * (1 << F) + 50) / 100;

   localparam logic [XW-1:0]  X_LOW  = XW'(LOW_Q);
   localparam logic [XW-1:0]  X_HALF = XW'(1) << (F - 1);
   localparam logic [XW-1:0]  X_HIGH = XW'(HIGH_Q);
   localparam logic [SCW-1:0] XS_SAT = SCW'(1) << (F + INT_BITS);

   localparam logic signed [VW-1:0] V_FULL  = VW'(CH_FULL) << F;
   localparam logic signed [VW-1:0] V_GREY  = VW'(CH_GREY) << F;
   localparam logic signed [VW-1:0] V_ONE   = VW'(1) << F;
   localparam logic signed [VW-1:0] V_LOW   = VW'(LOW_Q);
   localparam logic signed [VW-1:0] V_HALF  = VW'(1) << (F - 1);
   localparam logic signed [VW-1:0] V_HIGH  = VW'(HIGH_Q);
   localparam logic signed [VW-1:0] V_CH    = VW'(CH_FULL);
   localparam logic signed [VW-1:0] V_GSLP  = VW'(RAMP_G_SLOPE);
   localparam logic signed [VW-1:0] V_RSLP  = VW'(RAMP_R_SLOPE);
   localparam logic signed [VW-1:0] V_BSTEP = VW'(RAMP_B_STEP);
   localparam logic signed [VW-1:0] V_GSTEP = VW'(RAMP_G_STEP);

   logic                        a_valid_ff;
   logic signed [VW-1:0]        vr_ff, vg_ff, vb_ff;
   logic signed [VW-1:0]        vr_in, vg_in, vb_in;

   logic                        rsp_valid_ff;
   logic [CHANNEL_BITS-1:0]     red_ff, green_ff, blue_ff;

   function automatic logic [CHANNEL_BITS-1:0] chan(input logic signed [VW-1:0] v);
      logic [CHANNEL_BITS-1:0] c;
      if (v[VW-1] || (v == '0)) begin
         c = '0;
      end else if (|v[VW-2:F+CHANNEL_BITS]) begin
         c = CHANNEL_BITS'(CH_FULL);
      end else begin
         c = v[F+CHANNEL_BITS-1:F];
      end
      return c;
   endfunction

   always_comb begin
      logic [XW-1:0]           q_half, x;
      logic [SCW-1:0]          xs;
      logic [CHANNEL_BITS-1:0] dr, dg, db;
      logic [PW-1:0]           pr, pg, pb;
      logic signed [VW-1:0]    xv, ar, ag, ab, sr, sg, sb;
      q_half = (ctl_i.sat || (q_i > QW'(X_HALF))) ? X_HALF : XW'(q_i);
      x      = (ctl_i.mode == MODE_RAMP_UPPER) ? (X_HALF + q_half) : q_half;
      xs     = ctl_i.sat ? XS_SAT : SCW'(q_i);
      dr     = CHANNEL_BITS'(CH_FULL) - shade_colour[7:0];
      dg     = CHANNEL_BITS'(CH_FULL) - shade_colour[15:8];
      db     = CHANNEL_BITS'(CH_FULL) - shade_colour[23:16];
      pr     = PW'(xs) * PW'(dr);
      pg     = PW'(xs) * PW'(dg);
      pb     = PW'(xs) * PW'(db);
      sr     = V_FULL - signed'(VW'(pr));
      sg     = V_FULL - signed'(VW'(pg));
      sb     = V_FULL - signed'(VW'(pb));
      xv     = signed'(VW'(x));
      if (x <= X_LOW) begin
         ar = '0;
         ag = xv * V_GSLP;
         ab = V_FULL;
      end else if (x <= X_HALF) begin
         ar = '0;
         ag = V_FULL;
         ab = (V_ONE - V_BSTEP * (xv - V_LOW)) * V_CH;
      end else if (x <= X_HIGH) begin
         ar = (xv - V_HALF) * V_RSLP;
         ag = V_FULL;
         ab = '0;
      end else begin
         ar = V_FULL;
         ag = (V_ONE - V_GSTEP * (xv - V_HIGH)) * V_CH;
         ab = '0;
      end
      unique case (ctl_i.mode) inside
         MODE_SHADE_GREY: begin
            vr_in = V_GREY;
            vg_in = V_GREY;
            vb_in = V_GREY;
         end
         MODE_SHADE_WHITE: begin
            vr_in = V_FULL;
            vg_in = V_FULL;
            vb_in = V_FULL;
         end
         MODE_SHADE_DIV: begin
            vr_in = sr;
            vg_in = sg;
            vb_in = sb;
         end
         MODE_RAMP_GREEN: begin
            vr_in = '0;
            vg_in = V_FULL;
            vb_in = '0;
         end
         MODE_RAMP_LOWER, MODE_RAMP_UPPER: begin
            vr_in = ar;
            vg_in = ag;
            vb_in = ab;
         end
         default: begin
            vr_in = '0;
            vg_in = '0;
            vb_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_a) begin
            a_valid_ff <= ctl_i.valid;
         end
         if (load_b) begin
            rsp_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a) begin
         vr_ff <= vr_in;
         vg_ff <= vg_in;
         vb_ff <= vb_in;
      end
      if (load_b) begin
         red_ff   <= chan(vr_ff);
         green_ff <= chan(vg_ff);
         blue_ff  <= chan(vb_ff);
      end
   end

   assign a_valid   = a_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

endmodule

>>> hw/rtl/height_to_colour_ramp.sv
// ----------------------------------------------------------------------------
// height_to_colour_ramp
// Maps each signed height to an 8-bit RGB colour, either on a blue-green-red
// ramp split at the mid height or as a fade from white toward a shade colour.
// One height is taken per clock while the input is not stalled; each result
// passes the front stage, a row of divider cells, one cell per quotient bit
// (8 integer and FRACTION_BITS fraction bits), and two colour stages. Every
// stage holds its own item, so a stalled output only blocks the input once
// all stages are full. Registers are written through the csr port; the user
// must write them between streams, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module height_to_colour_ramp #(
   parameter int HEIGHT_WIDTH  = 32,
   parameter int FRACTION_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,

   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [HEIGHT_WIDTH-1:0]     req_height,

   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_red,
   output logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_green,
   output logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_blue,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hcr_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [(HEIGHT_WIDTH > hcr_pkg::SHADE_WIDTH ?
                  HEIGHT_WIDTH : hcr_pkg::SHADE_WIDTH)-1:0] csr_data
);

   import hcr_pkg::*;

   localparam int DW     = HEIGHT_WIDTH + 1;
   localparam int QW     = FRACTION_BITS + INT_BITS;
   localparam int NSTAGE = QW + 3;

   logic signed [HEIGHT_WIDTH-1:0] range_min_ff, range_mid_ff, range_max_ff;
   logic                           reverse_map_ff, blended_mode_ff;
   logic [SHADE_WIDTH-1:0]         shade_colour_ff;

   ctl_type             ctl_s   [0:QW];
   logic [DW-1:0]       rem_s   [0:QW];
   logic [INT_BITS-1:0] nbits_s [0:QW];
   logic [DW-1:0]       den_s   [0:QW];
   logic [QW-1:0]       q_s     [0:QW];

   logic [NSTAGE-1:0]   vld;
   logic [NSTAGE-1:0]   rdy;
   logic                a_valid;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff    <= '0;
         range_mid_ff    <= '0;
         range_max_ff    <= '0;
         reverse_map_ff  <= 1'b0;
         blended_mode_ff <= 1'b1;
         shade_colour_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_RANGE_MIN:    range_min_ff    <= csr_data[HEIGHT_WIDTH-1:0];
            REG_RANGE_MID:    range_mid_ff    <= csr_data[HEIGHT_WIDTH-1:0];
            REG_RANGE_MAX:    range_max_ff    <= csr_data[HEIGHT_WIDTH-1:0];
            REG_REVERSE_MAP:  reverse_map_ff  <= csr_data[0];
            REG_BLENDED_MODE: blended_mode_ff <= csr_data[0];
            REG_SHADE_COLOUR: shade_colour_ff <= csr_data[SHADE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // per-stage transfer control
   genvar s;
   generate
      for (s = 0; s <= QW; s++) begin : g_vld
         assign vld[s] = ctl_s[s].valid;
      end
      for (s = 0; s < NSTAGE - 1; s++) begin : g_rdy
         assign rdy[s] = ~vld[s] | rdy[s+1];
      end
   endgenerate

   assign vld[QW+1]        = a_valid;
   assign vld[QW+2]        = rsp_valid;
   assign rdy[NSTAGE-1]    = ~vld[NSTAGE-1] | ~rsp_stall;
   assign req_stall        = ~rdy[0];

   hcr_front #(
      .HEIGHT_WIDTH (HEIGHT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .load         (rdy[0]),
      .in_valid     (req_valid),
      .height       (req_height),
      .range_min    (range_min_ff),
      .range_mid    (range_mid_ff),
      .range_max    (range_max_ff),
      .reverse_map  (reverse_map_ff),
      .blended_mode (blended_mode_ff),
      .ctl_o        (ctl_s[0]),
      .rem_o        (rem_s[0]),
      .nbits_o      (nbits_s[0]),
      .den_o        (den_s[0])
   );

   assign q_s[0] = '0;

   generate
      for (s = 0; s < QW; s++) begin : g_cell
         hcr_cell #(
            .DW (DW),
            .QW (QW)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .load    (rdy[s+1]),
            .ctl_i   (ctl_s[s]),
            .rem_i   (rem_s[s]),
            .nbits_i (nbits_s[s]),
            .den_i   (den_s[s]),
            .q_i     (q_s[s]),
            .ctl_o   (ctl_s[s+1]),
            .rem_o   (rem_s[s+1]),
            .nbits_o (nbits_s[s+1]),
            .den_o   (den_s[s+1]),
            .q_o     (q_s[s+1])
         );
      end
   endgenerate

   hcr_colour #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_colour (
      .clock        (clock),
      .reset        (reset),
      .load_a       (rdy[QW+1]),
      .load_b       (rdy[QW+2]),
      .ctl_i        (ctl_s[QW]),
      .q_i          (q_s[QW]),
      .shade_colour (shade_colour_ff),
      .a_valid      (a_valid),
      .rsp_valid    (rsp_valid),
      .red          (rsp_red),
      .green        (rsp_green),
      .blue         (rsp_blue)
   );

endmodule

>>> hw/rtl/hcr_checker.sv
// ----------------------------------------------------------------------------
// hcr_checker
// Port-level checks of the height to colour ramp: output hold under stall,
// reset behavior and how input stall follows output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcr_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_red,
   input logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_green,
   input logic [hcr_pkg::CHANNEL_BITS-1:0]   rsp_blue
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_red)
         && $stable(rsp_green) && $stable(rsp_blue))
      else $error("stalled result changed");

   // reset empties the output
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input only stalls when a result waits under output stall
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   // a free output frees the input in the same cycle
   a_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output free");

endmodule

bind height_to_colour_ramp hcr_checker u_hcr_checker (.*);

>>> verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for height_to_colour_ramp. A directed table covers the
// reset state, the extremes and the empty or disordered range cases, then
// random phases switch the range registers and modes between streams of
// heights. Each colour is predicted when its height transfer happens and is
// compared with the next rsp transfer, with random input gaps and output
// stalls and one long output hold that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import hcr_pkg::*;

   localparam int HW              = 32;
   localparam int FB              = 16;
   localparam int CSR_W           = HW > SHADE_WIDTH ? HW : SHADE_WIDTH;
   localparam int LATENCY         = FB + 11;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_CYCLES     = 80;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int REPORT_LIMIT    = 10;
   localparam int DIRECTED_ROWS   = 26;

   localparam longint ONE_Q  = longint'(1) << FB;
   localparam longint HALF_Q = ONE_Q >> 1;
   localparam longint LOW_Q  = (33 * ONE_Q + 50) / 100;
   localparam longint HIGH_Q = (66 * ONE_Q + 50) / 100;

   localparam logic signed [HW-1:0] H_MIN = {1'b1, {(HW-1){1'b0}}};
   localparam logic signed [HW-1:0] H_MAX = ~H_MIN;

   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

   typedef struct packed {
      logic [CHANNEL_BITS-1:0] red;
      logic [CHANNEL_BITS-1:0] green;
      logic [CHANNEL_BITS-1:0] blue;
   } colour_type;

   typedef struct packed {
      logic signed [HW-1:0]   lo;
      logic signed [HW-1:0]   mid;
      logic signed [HW-1:0]   hi;
      logic                   rev;
      logic                   blend;
      logic [SHADE_WIDTH-1:0] shade;
   } ramp_cfg_type;

   typedef struct packed {
      ramp_cfg_type         cfg;
      logic signed [HW-1:0] height;
      logic                 typed;
      colour_type           colour;
   } plan_row_type;

   localparam colour_type C_NONE  = '0;
   localparam colour_type C_GREEN = '{8'd0, 8'd255, 8'd0};
   localparam colour_type C_BLUE  = '{8'd0, 8'd0, 8'd255};
   localparam colour_type C_RED   = '{8'd255, 8'd0, 8'd0};
   localparam colour_type C_WHITE = '{8'd255, 8'd255, 8'd255};
   localparam colour_type C_GREY  = '{8'd127, 8'd127, 8'd127};

   localparam ramp_cfg_type CFG_RESET     = '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_GREY      = '{32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b0, 24'h0};
   localparam ramp_cfg_type CFG_SYM       = '{-32'sd1000, 32'sd0, 32'sd1000, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_SYM_REV   = '{-32'sd1000, 32'sd0, 32'sd1000, 1'b1, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_TOP_EMPTY = '{-32'sd500, 32'sd500, 32'sd500, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_BOT_EMPTY = '{-32'sd500, -32'sd500, 32'sd500, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_TOP_FLIP  = '{-32'sd100, 32'sd500, 32'sd200, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_BOT_FLIP  = '{32'sd100, -32'sd100, 32'sd500, 1'b0, 1'b1, 24'h0};
   localparam ramp_cfg_type CFG_SHADE_RED = '{-32'sd1000, 32'sd0, 32'sd1000, 1'b0, 1'b0,
                                             24'h0000ff};
   localparam ramp_cfg_type CFG_WIDE      = '{H_MIN, 32'sd0, H_MAX, 1'b1, 1'b0, 24'h804020};

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   logic signed [HW-1:0]      req_height  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   logic [CHANNEL_BITS-1:0]   rsp_red;
   logic [CHANNEL_BITS-1:0]   rsp_green;
   logic [CHANNEL_BITS-1:0]   rsp_blue;
   logic                      csr_valid   = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_W-1:0]          csr_data    = '0;

   colour_type   pending_colours[$];
   ramp_cfg_type cfg_now      = CFG_RESET;
   plan_row_type plan [DIRECTED_ROWS];
   bit           idling       = 1'b1;
   bit           hold_pending = 1'b0;
   int           failures     = 0;
   int           quiet_cycles = 0;

   height_to_colour_ramp #(
      .HEIGHT_WIDTH  (HW),
      .FRACTION_BITS (FB)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_height (req_height),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor(num * 2^FB / den), held at cap
   function automatic longint scaled_ratio(longint num, longint den, longint cap);
      longint q;
      q = (num <<< FB) / den;
      return q < cap ? q : cap;
   endfunction

   function automatic logic [CHANNEL_BITS-1:0] clip_channel(longint v);
      if (v <= 0) return '0;
      if ((v >>> FB) > CH_FULL) return 8'(CH_FULL);
      return 8'(v >>> FB);
   endfunction

   function automatic colour_type colour_of_height(ramp_cfg_type c, logic signed [HW-1:0] h);
      longint     z, lo, mid, hi, span, part, num, xs, x;
      colour_type o;
      lo   = c.lo;
      mid  = c.mid;
      hi   = c.hi;
      z    = h;
      span = hi - lo;
      o    = C_NONE;
      if (c.rev) z = lo + hi - z;
      if (!c.blend) begin
         if (span <= 0) o = C_GREY;
         else if (hi - z < 0) o = C_WHITE;
         else begin
            xs = scaled_ratio(hi - z, span, 256 * ONE_Q);
            o.red   = clip_channel(CH_FULL * ONE_Q - xs * (CH_FULL - longint'(c.shade[7:0])));
            o.green = clip_channel(CH_FULL * ONE_Q - xs * (CH_FULL - longint'(c.shade[15:8])));
            o.blue  = clip_channel(CH_FULL * ONE_Q - xs * (CH_FULL - longint'(c.shade[23:16])));
         end
      end else if (span <= 0) begin
         o = C_GREEN;
      end else begin
         if (z > mid) begin
            part = hi - mid;
            if (part == 0) x = ONE_Q;
            else if (part < 0) x = HALF_Q;
            else x = HALF_Q + scaled_ratio(z - mid, 2 * part, HALF_Q);
         end else begin
            part = mid - lo;
            num  = z - lo;
            if (part == 0) x = 0;
            else if (part > 0) x = num < 0 ? 0 : scaled_ratio(num, 2 * part, HALF_Q);
            else x = num > 0 ? 0 : scaled_ratio(-num, -2 * part, HALF_Q);
         end
         if (x <= LOW_Q) begin
            o.blue  = 8'(CH_FULL);
            o.green = clip_channel(x * RAMP_G_SLOPE);
         end else if (x <= HALF_Q) begin
            o.green = 8'(CH_FULL);
            o.blue  = clip_channel((ONE_Q - RAMP_B_STEP * (x - LOW_Q)) * CH_FULL);
         end else if (x <= HIGH_Q) begin
            o.green = 8'(CH_FULL);
            o.red   = clip_channel((x - HALF_Q) * RAMP_R_SLOPE);
         end else begin
            o.red   = 8'(CH_FULL);
            o.green = clip_channel((ONE_Q - RAMP_G_STEP * (x - HIGH_Q)) * CH_FULL);
         end
      end
      return o;
   endfunction

   function automatic ramp_cfg_type random_cfg(int kind);
      ramp_cfg_type         c;
      logic signed [HW-1:0] t;
      int                   span_lo, span_hi;
      span_lo = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 100000);
      span_hi = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : $urandom_range(1, 100000);
      c.rev   = 1'($urandom_range(0, 1));
      c.blend = 1'b1;
      c.shade = SHADE_WIDTH'($urandom);
      c.lo    = $urandom_range(0, 2000000) - 1000000;
      c.mid   = c.lo + span_lo;
      c.hi    = c.mid + span_hi;
      case (kind)
         1: begin
            c.lo    = H_MIN;
            c.hi    = H_MAX;
            c.mid   = $urandom;
            c.blend = 1'($urandom_range(0, 1));
         end
         2: begin
            c.lo  = $urandom;
            c.mid = $urandom;
            c.hi  = $urandom;
            if (c.lo > c.mid) begin t = c.lo; c.lo = c.mid; c.mid = t; end
            if (c.mid > c.hi) begin t = c.mid; c.mid = c.hi; c.hi = t; end
            if (c.lo > c.mid) begin t = c.lo; c.lo = c.mid; c.mid = t; end
         end
         3: begin
            c       = random_cfg($urandom_range(0, 1) * 2);
            c.blend = 1'b0;
         end
         4: begin
            c.blend = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 5))
               0: c.hi = c.lo;
               1: c.hi = c.lo - span_hi;
               2: c.mid = c.hi + span_hi;
               3: c.mid = c.lo - span_lo;
               4: c.mid = c.lo;
               default: c.mid = c.hi;
            endcase
         end
         default: ;
      endcase
      return c;
   endfunction

   function automatic logic signed [HW-1:0] random_height(ramp_cfg_type c);
      longint          lo, hi, margin, v;
      longint unsigned n;
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 4))
               0: return H_MIN;
               1: return H_MAX;
               2: return c.lo;
               3: return c.mid;
               default: return c.hi;
            endcase
         end
         default: begin
            lo = c.lo;
            hi = c.lo;
            if (c.mid < lo) lo = c.mid;
            if (c.hi < lo) lo = c.hi;
            if (c.mid > hi) hi = c.mid;
            if (c.hi > hi) hi = c.hi;
            margin = (hi - lo) / 4 + 2;
            n = longint'(hi - lo + 2 * margin + 1);
            v = lo - margin + longint'({$urandom, $urandom} % n);
            if (v < H_MIN) v = H_MIN;
            if (v > H_MAX) v = H_MAX;
            return v[HW-1:0];
         end
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_BITS-1:0] idx, input logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic apply_config(input ramp_cfg_type c);
      csr_write(REG_RANGE_MIN, CSR_W'(c.lo));
      csr_write(REG_RANGE_MID, CSR_W'(c.mid));
      csr_write(REG_RANGE_MAX, CSR_W'(c.hi));
      csr_write(REG_REVERSE_MAP, CSR_W'(c.rev));
      csr_write(REG_BLENDED_MODE, CSR_W'(c.blend));
      csr_write(REG_SHADE_COLOUR, CSR_W'(c.shade));
      // unused index, must leave every register alone
      csr_write($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CSR_W'($urandom));
      csr_valid <= 1'b0;
      cfg_now = c;
   endtask

   task automatic wait_drained();
      while (pending_colours.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_height(input logic signed [HW-1:0] h, input logic typed,
                              input colour_type fixed_colour);
      int gap;
      if (idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid  <= 1'b0;
         req_height <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_height <= h;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_colours.push_back(typed ? fixed_colour : colour_of_height(cfg_now, h));
      @(negedge clock);
   endtask

   // output side: random stall bursts, plus one long hold on request
   initial begin
      int burst;
      int held;
      burst = 0;
      held  = 0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            held         = HOLD_CYCLES;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else if (burst > 0) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (idling && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(1, 3) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      colour_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colours.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("unexpected rsp transfer: r %0d g %0d b %0d",
                        rsp_red, rsp_green, rsp_blue);
         end else begin
            want = pending_colours.pop_front();
            if (want.red != rsp_red || want.green != rsp_green || want.blue != rsp_blue) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("colour mismatch: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                           want.red, want.green, want.blue, rsp_red, rsp_green, rsp_blue);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("height_to_colour_ramp verification failed");
            $finish;
         end
      end
   end

   initial begin
      int i;
      int p;
      int k;
      int kind;
      plan = '{
         '{CFG_RESET,     32'sd0,     1'b1, C_GREEN},
         '{CFG_RESET,     H_MIN,      1'b1, C_GREEN},
         '{CFG_RESET,     H_MAX,      1'b1, C_GREEN},
         '{CFG_GREY,      32'sd5,     1'b1, C_GREY},
         '{CFG_SYM,       -32'sd1000, 1'b1, C_BLUE},
         '{CFG_SYM,       H_MIN,      1'b1, C_BLUE},
         '{CFG_SYM,       32'sd0,     1'b1, C_GREEN},
         '{CFG_SYM,       32'sd1000,  1'b1, C_RED},
         '{CFG_SYM,       H_MAX,      1'b1, C_RED},
         '{CFG_SYM,       -32'sd340,  1'b0, C_NONE},
         '{CFG_SYM,       -32'sd100,  1'b0, C_NONE},
         '{CFG_SYM,       32'sd200,   1'b0, C_NONE},
         '{CFG_SYM,       32'sd600,   1'b0, C_NONE},
         '{CFG_SYM_REV,   -32'sd1000, 1'b1, C_RED},
         '{CFG_SYM_REV,   H_MIN,      1'b0, C_NONE},
         '{CFG_TOP_EMPTY, 32'sd600,   1'b1, C_RED},
         '{CFG_BOT_EMPTY, -32'sd700,  1'b1, C_BLUE},
         '{CFG_TOP_FLIP,  32'sd600,   1'b1, C_GREEN},
         '{CFG_BOT_FLIP,  -32'sd300,  1'b1, C_GREEN},
         '{CFG_BOT_FLIP,  32'sd300,   1'b0, C_NONE},
         '{CFG_SHADE_RED, 32'sd1000,  1'b1, C_WHITE},
         '{CFG_SHADE_RED, 32'sd2000,  1'b1, C_WHITE},
         '{CFG_SHADE_RED, -32'sd1000, 1'b1, C_RED},
         '{CFG_SHADE_RED, H_MIN,      1'b1, C_RED},
         '{CFG_WIDE,      H_MIN,      1'b0, C_NONE},
         '{CFG_WIDE,      H_MAX,      1'b0, C_NONE}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         if (plan[i].cfg != cfg_now) begin
            req_valid <= 1'b0;
            wait_drained();
            apply_config(plan[i].cfg);
         end
         send_height(plan[i].height, plan[i].typed, plan[i].colour);
      end

      for (p = 0; p < RANDOM_PHASES; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         kind = p < 5 ? p : $urandom_range(0, 4);
         apply_config(random_cfg(kind));
         // back up the pipeline behind a long output hold
         if (p == 0) hold_pending = 1'b1;
         if (p == RANDOM_PHASES - 1) idling = 1'b0;
         for (k = 0; k < ITEMS_PER_PHASE; k++)
            send_height(random_height(cfg_now), 1'b0, C_NONE);
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      failures += pending_colours.size();
      if (failures == 0)
         $display("height_to_colour_ramp verification clean");
      else
         $display("height_to_colour_ramp verification failed");
      $finish;
   end

endmodule
